>>> rtl/core/register_machine_execute_unit_assert.svh
// assertion macros used by the execute unit rtl
`ifndef REGISTER_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define REGISTER_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, opcodes, sequencer states and control structs of the
// register machine execute unit.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int unsigned DATA_W         = 32;
    localparam int unsigned FUNC_W         = 4;
    localparam int unsigned REG_A_W        = 4;
    localparam int unsigned NEXT_PC_W      = 10;
    localparam int unsigned NUM_REGS_DEF   = 16;
    localparam int unsigned PROG_DEPTH_DEF = 1024;

    typedef enum logic [FUNC_W-1:0] {
        OP_JEZ   = 4'd0,
        OP_JNZ   = 4'd1,
        OP_JGZ   = 4'd2,
        OP_JLZ   = 4'd3,
        OP_SET   = 4'd4,
        OP_EXIT  = 4'd5,
        OP_PRINT = 4'd6,
        OP_IN    = 4'd7,
        OP_ADD   = 4'd8,
        OP_SUB   = 4'd9,
        OP_MUL   = 4'd10,
        OP_DIV   = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [NEXT_PC_W-1:0] next_pc;
        logic                 out_valid;
        logic [DATA_W-1:0]    out_value;
        logic                 halted;
        logic                 div_by_zero;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic sgn;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> rtl/core/rme_in_if.sv
// ----------------------------------------------------------------------------
// rme_in_if
// Instruction request channel: valid/ready handshake with decoded fields.
// ----------------------------------------------------------------------------
interface rme_in_if;

    logic                               valid;
    logic                               ready;
    logic [rme_pkg::FUNC_W-1:0]         func;
    logic [rme_pkg::REG_A_W-1:0]        reg_a;
    logic signed [rme_pkg::DATA_W-1:0]  operand_b;
    logic signed [rme_pkg::DATA_W-1:0]  in_value;

    modport source (output valid, func, reg_a, operand_b, in_value, input ready);
    modport sink   (input valid, func, reg_a, operand_b, in_value, output ready);

endinterface

>>> rtl/core/rme_out_if.sv
// ----------------------------------------------------------------------------
// rme_out_if
// Result channel: valid/ready handshake with one result per instruction.
// ----------------------------------------------------------------------------
interface rme_out_if;

    logic                               valid;
    logic                               ready;
    logic [rme_pkg::NEXT_PC_W-1:0]      next_pc;
    logic                               out_valid;
    logic signed [rme_pkg::DATA_W-1:0]  out_value;
    logic                               halted;
    logic                               div_by_zero;

    modport source (output valid, next_pc, out_valid, out_value, halted, div_by_zero,
                    input ready);
    modport sink   (input valid, next_pc, out_valid, out_value, halted, div_by_zero,
                    output ready);

endinterface

>>> rtl/core/rme_regfile.sv
// ----------------------------------------------------------------------------
// rme_regfile
// Register file memory: one write port, two registered read ports, per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rme_regfile #(
    parameter int unsigned NUM_REGS = rme_pkg::NUM_REGS_DEF,
    localparam int unsigned IDX_W   = $clog2(NUM_REGS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [IDX_W-1:0]           i_wr_addr,
    input  logic [rme_pkg::DATA_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]           i_rd_addr_a,
    input  logic [IDX_W-1:0]           i_rd_addr_b,
    output logic [rme_pkg::DATA_W-1:0] o_rd_data_a,
    output logic [rme_pkg::DATA_W-1:0] o_rd_data_b
);

    logic [rme_pkg::DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]        r_vld;
    logic [rme_pkg::DATA_W-1:0] r_rd_a;
    logic [rme_pkg::DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a] : '0;
        r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b] : '0;
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/core/rme_divider.sv
// ----------------------------------------------------------------------------
// rme_divider
// Shared iterative restoring divider, one quotient bit per cycle. Signed mode
// truncates toward zero; unsigned mode also serves index and target reduction.
// ----------------------------------------------------------------------------
module rme_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rme_pkg::t_div_ctl          i_ctl,
    input  logic [rme_pkg::DATA_W-1:0] i_num,
    input  logic [rme_pkg::DATA_W-1:0] i_den,
    output rme_pkg::t_div_sts          o_sts,
    output logic [rme_pkg::DATA_W-1:0] o_quo,
    output logic [rme_pkg::DATA_W-1:0] o_rem
);

    localparam int unsigned DW    = rme_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_qneg;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic             num_neg;
    logic             den_neg;
    logic [DW-1:0]    num_abs;
    logic [DW-1:0]    den_abs;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;

    assign num_neg = i_ctl.sgn & i_num[DW-1];
    assign den_neg = i_ctl.sgn & i_den[DW-1];
    assign num_abs = num_neg ? (DW'(0) - i_num) : i_num;
    assign den_abs = den_neg ? (DW'(0) - i_den) : i_den;
    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign diff    = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_cnt  <= CNT_W'(DW);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_qneg <= num_neg ^ den_neg;
            r_quo  <= num_abs;
            r_rem  <= '0;
            r_den  <= den_abs;
        end else if (r_cnt != '0) begin
            if (!diff[DW]) begin
                r_rem <= diff[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quo      = r_qneg ? (DW'(0) - r_quo) : r_quo;
    assign o_rem      = r_rem;

endmodule

>>> rtl/core/register_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes one decoded register machine instruction per request against a
// register file, a program counter and a halt flag; one result per request.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle; the result then sits
// in an output register, so the next request is taken while it waits. Jumps,
// set, in, add, sub, print, exit and unused codes pass the read, execute and
// result states, mul adds one registered multiply, and div waits in its own
// state on the 32-step shared divider; a div with a zero divisor skips the
// divider. When NUM_REGS is not a power of two, add/sub/mul/div first reduce
// operand_b to a register index through the same divider, and when PROG_DEPTH
// is not a power of two the jumps reduce their target the same way. A request
// that arrives after exit goes straight to the result state. There is no
// clearing pass: the register file reads zero until an entry is written.
module register_machine_execute_unit #(
    parameter int unsigned NUM_REGS   = rme_pkg::NUM_REGS_DEF,
    parameter int unsigned PROG_DEPTH = rme_pkg::PROG_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rme_in_if.sink     i_req,
    rme_out_if.source  o_rsp
);

`include "register_machine_execute_unit_assert.svh"

    localparam int unsigned DW     = rme_pkg::DATA_W;
    localparam int unsigned RA_W   = rme_pkg::REG_A_W;
    localparam int unsigned NPC_W  = rme_pkg::NEXT_PC_W;
    localparam int unsigned IDX_W  = $clog2(NUM_REGS);
    localparam int unsigned PC_W   = $clog2(PROG_DEPTH);
    localparam int unsigned RED_W  = (IDX_W > RA_W) ? IDX_W : RA_W;
    localparam bit REGS_POW2       = (NUM_REGS & (NUM_REGS - 1)) == 0;
    localparam bit DEPTH_POW2      = (PROG_DEPTH & (PROG_DEPTH - 1)) == 0;

    rme_pkg::t_state             r_state, n_state;
    logic [rme_pkg::FUNC_W-1:0]  r_func, n_func;
    logic [IDX_W-1:0]            r_ia, n_ia;
    logic [IDX_W-1:0]            r_ib, n_ib;
    logic [DW-1:0]               r_opb, n_opb;
    logic [DW-1:0]               r_inv, n_inv;
    logic [PC_W-1:0]             r_target, n_target;
    logic [PC_W-1:0]             r_pc, n_pc;
    logic                        r_halt, n_halt;
    logic [DW-1:0]               r_prod, n_prod;
    rme_pkg::t_rsp               r_res, n_res;
    rme_pkg::t_rsp               r_out;
    logic                        r_out_vld;

    logic                        out_load;
    logic [PC_W-1:0]             pc_inc;
    logic                        taken;
    logic [RED_W-1:0]            ia_red;
    logic                        need_red;

    logic                        wr_en;
    logic [DW-1:0]               wr_data;
    logic [DW-1:0]               ra;
    logic [DW-1:0]               rb;

    rme_pkg::t_div_ctl           div_ctl;
    rme_pkg::t_div_sts           div_sts;
    logic [DW-1:0]               div_num;
    logic [DW-1:0]               div_den;
    logic [DW-1:0]               div_quo;
    logic [DW-1:0]               div_rem;

    rme_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_ia),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (r_ia),
        .i_rd_addr_b (r_ib),
        .o_rd_data_a (ra),
        .o_rd_data_b (rb)
    );

    rme_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // reg_a modulo NUM_REGS on four bits
    always_comb begin
        ia_red = RED_W'(i_req.reg_a);
        for (int k = 0; k < 8; k++) begin
            if (ia_red >= NUM_REGS) begin
                ia_red = ia_red - RED_W'(NUM_REGS);
            end
        end
    end

    assign pc_inc = (r_pc == PC_W'(PROG_DEPTH - 1)) ? '0 : (r_pc + PC_W'(1));

    always_comb begin
        case (i_req.func) inside
            rme_pkg::OP_JEZ, rme_pkg::OP_JNZ, rme_pkg::OP_JGZ, rme_pkg::OP_JLZ:
                need_red = !DEPTH_POW2;
            rme_pkg::OP_ADD, rme_pkg::OP_SUB, rme_pkg::OP_MUL, rme_pkg::OP_DIV:
                need_red = !REGS_POW2;
            default:
                need_red = 1'b0;
        endcase
    end

    always_comb begin
        unique case (rme_pkg::t_op'(r_func))
            rme_pkg::OP_JEZ: taken = (ra == '0);
            rme_pkg::OP_JNZ: taken = (ra != '0);
            rme_pkg::OP_JGZ: taken = (ra != '0) && !ra[DW-1];
            rme_pkg::OP_JLZ: taken = ra[DW-1];
            default:         taken = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_ia     = r_ia;
        n_ib     = r_ib;
        n_opb    = r_opb;
        n_inv    = r_inv;
        n_target = r_target;
        n_pc     = r_pc;
        n_halt   = r_halt;
        n_prod   = r_prod;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_data  = r_opb;
        div_ctl  = '{start: 1'b0, sgn: 1'b0};
        div_num  = ra;
        div_den  = rb;
        out_load = 1'b0;
        i_req.ready = 1'b0;

        unique case (r_state)
            rme_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                div_num = i_req.operand_b;
                div_den = DW'(NUM_REGS);
                if (i_req.func inside {rme_pkg::OP_JEZ, rme_pkg::OP_JNZ,
                                       rme_pkg::OP_JGZ, rme_pkg::OP_JLZ}) begin
                    div_den = DW'(PROG_DEPTH);
                end
                if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_ia     = IDX_W'(ia_red);
                    n_ib     = i_req.operand_b[IDX_W-1:0];
                    n_opb    = i_req.operand_b;
                    n_inv    = i_req.in_value;
                    n_target = i_req.operand_b[PC_W-1:0];
                    if (r_halt) begin
                        n_res   = '{next_pc: NPC_W'(r_pc), out_valid: 1'b0, out_value: '0,
                                    halted: 1'b1, div_by_zero: 1'b0};
                        n_state = rme_pkg::S_DONE;
                    end else if (need_red) begin
                        div_ctl = '{start: 1'b1, sgn: 1'b0};
                        n_state = rme_pkg::S_REDUCE;
                    end else begin
                        n_state = rme_pkg::S_READ;
                    end
                end
            end
            rme_pkg::S_REDUCE: begin
                if (div_sts.done) begin
                    n_ib     = IDX_W'(div_rem);
                    n_target = PC_W'(div_rem);
                    n_state  = rme_pkg::S_READ;
                end
            end
            rme_pkg::S_READ: begin
                n_state = rme_pkg::S_EXEC;
            end
            rme_pkg::S_EXEC: begin
                n_pc    = taken ? r_target : pc_inc;
                n_res   = '{next_pc: NPC_W'(n_pc), out_valid: 1'b0, out_value: '0,
                            halted: 1'b0, div_by_zero: 1'b0};
                n_state = rme_pkg::S_DONE;
                div_num = ra;
                div_den = rb;
                case (r_func)
                    rme_pkg::OP_SET: begin
                        wr_en   = 1'b1;
                        wr_data = r_opb;
                    end
                    rme_pkg::OP_EXIT: begin
                        n_halt       = 1'b1;
                        n_res.halted = 1'b1;
                    end
                    rme_pkg::OP_PRINT: begin
                        n_res.out_valid = 1'b1;
                        n_res.out_value = ra;
                    end
                    rme_pkg::OP_IN: begin
                        wr_en   = 1'b1;
                        wr_data = r_inv;
                    end
                    rme_pkg::OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = ra + rb;
                    end
                    rme_pkg::OP_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = ra - rb;
                    end
                    rme_pkg::OP_MUL: begin
                        n_prod  = ra * rb;
                        n_state = rme_pkg::S_MUL;
                    end
                    rme_pkg::OP_DIV: begin
                        if (rb == '0) begin
                            n_res.div_by_zero = 1'b1;
                        end else begin
                            div_ctl = '{start: 1'b1, sgn: 1'b1};
                            n_state = rme_pkg::S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rme_pkg::S_MUL: begin
                wr_en   = 1'b1;
                wr_data = r_prod;
                n_state = rme_pkg::S_DONE;
            end
            rme_pkg::S_DIV: begin
                if (div_sts.done) begin
                    wr_en   = 1'b1;
                    wr_data = div_quo;
                    n_state = rme_pkg::S_DONE;
                end
            end
            rme_pkg::S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = rme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rme_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rme_pkg::S_IDLE;
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_ia     <= n_ia;
        r_ib     <= n_ib;
        r_opb    <= n_opb;
        r_inv    <= n_inv;
        r_target <= n_target;
        r_prod   <= n_prod;
        r_res    <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.next_pc     = r_out.next_pc;
    assign o_rsp.out_valid   = r_out.out_valid;
    assign o_rsp.out_value   = r_out.out_value;
    assign o_rsp.halted      = r_out.halted;
    assign o_rsp.div_by_zero = r_out.div_by_zero;

    `RME_ASSERT_NXT(a_busy_after_req, i_req.valid && i_req.ready,
        r_state != rme_pkg::S_IDLE, "sequencer idle right after a request")
    `RME_ASSERT_NXT(a_halt_sticky, r_halt, r_halt, "halt flag cleared without reset")
    `RME_ASSERT_NXT(a_div_done_exit, r_state == rme_pkg::S_DIV && div_sts.done,
        r_state == rme_pkg::S_DONE, "divide finished without reaching result state")
    `RME_ASSERT_NOW(a_div_idle_when_free, r_state == rme_pkg::S_IDLE,
        !div_sts.busy, "divider busy while sequencer idle")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for register_machine_execute_unit. Instruction requests
// go in over a valid/ready channel, and a local model of the register file,
// the program counter and the halt flag predicts each result. A monitor checks
// every result field against the oldest prediction. The run covers directed
// boundary cases, a long output stall, a weighted random program, and exit
// followed by requests on the halted machine.
// ----------------------------------------------------------------------------
module testbench;

    import rme_pkg::*;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned QUIET_ITEMS   = 100;
    localparam int unsigned IDLE_PCT      = 12;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned BURST_ITEMS   = 12;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned TIMEOUT_LIMIT = 20_000_000;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 4'd12;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 4'd15;

    logic i_clk;
    logic i_rst_n;

    rme_in_if  req_if ();
    rme_out_if rsp_if ();

    register_machine_execute_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [DATA_W-1:0]    model_regs [NUM_REGS_DEF];
    logic [NEXT_PC_W-1:0] model_pc;
    logic                 model_halted;
    t_rsp                 expected_rsp [$];

    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned print_count;
    int unsigned div_zero_count;
    int unsigned jump_taken_count;
    int unsigned mismatch_count;
    int unsigned hold_request;
    bit          sender_idles;
    bit          receiver_idles;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] trunc_div(input logic [DATA_W-1:0] num,
                                                    input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] un;
        logic [DATA_W-1:0] ud;
        logic [DATA_W-1:0] q;
        un = num[DATA_W-1] ? -num : num;
        ud = den[DATA_W-1] ? -den : den;
        q  = un / ud;
        return (num[DATA_W-1] != den[DATA_W-1]) ? -q : q;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic execute_model(input logic [FUNC_W-1:0] f, input logic [REG_A_W-1:0] a,
                                 input logic [DATA_W-1:0] opb, input logic [DATA_W-1:0] inv);
        t_rsp                 r;
        int unsigned          ia;
        int unsigned          ib;
        logic [DATA_W-1:0]    ra;
        logic [DATA_W-1:0]    rb;
        logic [NEXT_PC_W-1:0] npc;
        logic [NEXT_PC_W-1:0] target;
        logic                 taken;
        r     = '0;
        taken = 1'b0;
        if (model_halted) begin
            r.next_pc = model_pc;
            r.halted  = 1'b1;
            expected_rsp.push_back(r);
            return;
        end
        ia     = a % NUM_REGS_DEF;
        ib     = opb % NUM_REGS_DEF;
        ra     = model_regs[ia];
        rb     = model_regs[ib];
        target = NEXT_PC_W'(opb % PROG_DEPTH_DEF);
        npc    = NEXT_PC_W'((32'(model_pc) + 1) % PROG_DEPTH_DEF);
        case (f)
            OP_JEZ:   taken = (ra == '0);
            OP_JNZ:   taken = (ra != '0);
            OP_JGZ:   taken = (ra != '0) && !ra[DATA_W-1];
            OP_JLZ:   taken = ra[DATA_W-1];
            OP_SET:   model_regs[ia] = opb;
            OP_EXIT:  model_halted = 1'b1;
            OP_PRINT: begin
                r.out_valid = 1'b1;
                r.out_value = ra;
                print_count++;
            end
            OP_IN:    model_regs[ia] = inv;
            OP_ADD:   model_regs[ia] = ra + rb;
            OP_SUB:   model_regs[ia] = ra - rb;
            OP_MUL:   model_regs[ia] = ra * rb;
            OP_DIV: begin
                if (rb == '0) begin
                    r.div_by_zero = 1'b1;
                    div_zero_count++;
                end else begin
                    model_regs[ia] = trunc_div(ra, rb);
                end
            end
            default: ;
        endcase
        if (taken) begin
            npc = target;
            jump_taken_count++;
        end
        model_pc  = npc;
        r.next_pc = model_pc;
        r.halted  = model_halted;
        expected_rsp.push_back(r);
    endtask

    // one request, with random idle cycles ahead of it while sender_idles is set
    task automatic send_instr(input logic [FUNC_W-1:0] f, input logic [REG_A_W-1:0] a,
                              input logic [DATA_W-1:0] opb, input logic [DATA_W-1:0] inv);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.reg_a     <= a;
        req_if.operand_b <= opb;
        req_if.in_value  <= inv;
        do @(posedge i_clk); while (!req_if.ready);
        execute_model(f, a, opb, inv);
        sent_count++;
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_instr(OP_PRINT, 4'd0, 32'd0, 32'd0);
        send_instr(OP_JEZ, 4'd3, 32'hFFFF_FC05, 32'd0);
        send_instr(OP_JNZ, 4'd3, 32'd7, 32'd0);
    endtask

    task automatic test_loads_and_jumps();
        send_instr(OP_SET, 4'd1, 32'h7FFF_FFFF, 32'd0);
        send_instr(OP_SET, 4'd2, 32'h8000_0000, 32'd0);
        send_instr(OP_SET, 4'd3, 32'hFFFF_FFFF, 32'd0);
        send_instr(OP_IN, 4'd4, 32'hFFFF_FFFF, 32'h8000_0000);
        send_instr(OP_IN, 4'd5, 32'd0, 32'h7FFF_FFFF);
        send_instr(OP_JGZ, 4'd1, 32'd100, 32'd0);
        send_instr(OP_JGZ, 4'd2, 32'd300, 32'd0);
        send_instr(OP_JLZ, 4'd2, 32'd200, 32'd0);
        send_instr(OP_JLZ, 4'd1, 32'd400, 32'd0);
    endtask

    task automatic test_arithmetic();
        // source index comes from the low bits only
        send_instr(OP_ADD, 4'd1, 32'hFFFF_FFF1, 32'd0);
        send_instr(OP_SUB, 4'd2, 32'd5, 32'd0);
        send_instr(OP_MUL, 4'd3, 32'd3, 32'd0);
        send_instr(OP_PRINT, 4'd1, 32'd0, 32'd0);
    endtask

    task automatic test_division();
        send_instr(OP_SET, 4'd8, 32'hFFFF_FFFF, 32'd0);
        send_instr(OP_DIV, 4'd4, 32'd8, 32'd0);
        send_instr(OP_DIV, 4'd6, 32'd0, 32'd0);
        send_instr(OP_SET, 4'd9, 32'hFFFF_FFF9, 32'd0);
        send_instr(OP_SET, 4'd10, 32'd2, 32'd0);
        send_instr(OP_DIV, 4'd9, 32'd10, 32'd0);
        send_instr(OP_PRINT, 4'd9, 32'd0, 32'd0);
    endtask

    task automatic test_spare_codes_and_wrap();
        send_instr(FUNC_SPARE_FIRST, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr(FUNC_SPARE_LAST, 4'd15, 32'd0, 32'd0);
        send_instr(OP_SET, 4'd15, 32'h1234_5678, 32'd0);
        send_instr(OP_JNZ, 4'd15, 32'd1023, 32'd0);
        send_instr(OP_PRINT, 4'd15, 32'd0, 32'd0);
    endtask

    task automatic test_backpressure();
        sender_idles = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            send_instr(OP_PRINT, 4'($urandom_range(0, 15)), $urandom(), $urandom());
        end
        wait_for_results();
    endtask

    task automatic test_random_program();
        logic [FUNC_W-1:0]  f;
        logic [REG_A_W-1:0] a;
        logic [DATA_W-1:0]  opb;
        logic [DATA_W-1:0]  inv;
        int unsigned        pick;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sender_idles   = (i >= QUIET_ITEMS);
            receiver_idles = (i >= QUIET_ITEMS);
            a    = 4'($urandom_range(0, 15));
            opb  = $urandom();
            inv  = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                f   = OP_SET;
                opb = pick_operand();
            end else if (pick < 28) begin
                f   = OP_IN;
                inv = pick_operand();
            end else if (pick < 46) begin
                f = 4'($urandom_range(OP_ADD, OP_MUL));
            end else if (pick < 56) begin
                f = OP_DIV;
            end else if (pick < 74) begin
                f = 4'($urandom_range(OP_JEZ, OP_JLZ));
            end else if (pick < 86) begin
                f = OP_PRINT;
            end else if (pick < 92) begin
                f = 4'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            end else begin
                // noise: any code but exit
                do f = 4'($urandom_range(0, 15)); while (f == OP_EXIT);
            end
            send_instr(f, a, opb, inv);
        end
        wait_for_results();
    endtask

    task automatic test_exit_and_halt();
        send_instr(OP_EXIT, 4'd0, 32'd0, 32'd0);
        send_instr(OP_PRINT, 4'd1, 32'd0, 32'd0);
        send_instr(OP_SET, 4'd2, 32'hFFFF_FFFF, 32'd0);
        send_instr(OP_DIV, 4'd4, 32'd0, 32'd0);
        send_instr(OP_JNZ, 4'd1, 32'd500, 32'd0);
        wait_for_results();
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.func      <= '0;
        req_if.reg_a     <= '0;
        req_if.operand_b <= '0;
        req_if.in_value  <= '0;
        rsp_if.ready     <= 1'b0;
        foreach (model_regs[i]) model_regs[i] = '0;
        model_pc         = '0;
        model_halted     = 1'b0;
        sent_count       = 0;
        checked_count    = 0;
        print_count      = 0;
        div_zero_count   = 0;
        jump_taken_count = 0;
        mismatch_count   = 0;
        hold_request     = 0;
        sender_idles     = 1'b1;
        receiver_idles   = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_loads_and_jumps();
        test_arithmetic();
        test_division();
        test_spare_codes_and_wrap();
        wait_for_results();
        test_backpressure();
        test_random_program();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        test_exit_and_halt();

        $display("run covered %0d requests and %0d checked results", sent_count, checked_count);
        $display("  %0d prints, %0d taken jumps, %0d zero divisors, then halt",
                 print_count, jump_taken_count, div_zero_count);
        if (mismatch_count == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : result_monitor
        int unsigned stall_left;
        t_rsp        exp_rsp;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    checked_count++;
                    if (rsp_if.next_pc !== exp_rsp.next_pc) begin
                        $error("next_pc: expected %0d, actual %0d",
                               exp_rsp.next_pc, rsp_if.next_pc);
                        mismatch_count++;
                    end
                    if (rsp_if.out_valid !== exp_rsp.out_valid) begin
                        $error("out_valid: expected %0b, actual %0b",
                               exp_rsp.out_valid, rsp_if.out_valid);
                        mismatch_count++;
                    end
                    if (rsp_if.out_value !== exp_rsp.out_value) begin
                        $error("out_value: expected %h, actual %h",
                               exp_rsp.out_value, rsp_if.out_value);
                        mismatch_count++;
                    end
                    if (rsp_if.halted !== exp_rsp.halted) begin
                        $error("halted: expected %0b, actual %0b",
                               exp_rsp.halted, rsp_if.halted);
                        mismatch_count++;
                    end
                    if (rsp_if.div_by_zero !== exp_rsp.div_by_zero) begin
                        $error("div_by_zero: expected %0b, actual %0b",
                               exp_rsp.div_by_zero, rsp_if.div_by_zero);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n || stall_left != 0) begin
                rsp_if.ready <= 1'b0;
                if (stall_left != 0) stall_left--;
            end else begin
                rsp_if.ready <= !(receiver_idles && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #(TIMEOUT_LIMIT);
        $display("timeout with %0d results outstanding", expected_rsp.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
